// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the peer source selector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Types and constants of the peer source selector.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

    // Peer table size, tied to the 4-bit slot field.
    localparam int          PEERS     = 16;
    localparam int          SLOT_W    = 4;
    localparam logic [3:0]  LAST_SLOT = 4'(PEERS - 1);

    // Request codes.
    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_HAVE   = 3'd2;
    localparam logic [2:0] REQ_UPDATE = 3'd3;
    localparam logic [2:0] REQ_SELECT = 3'd4;

    // Result status codes.
    localparam logic STAT_DONE   = 1'b0;
    localparam logic STAT_REJECT = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOCAL_SPEED  = 2'd0;
    localparam logic [1:0] CFG_TOTAL_CHUNKS = 2'd1;

    // Scoring constants.
    localparam logic [7:0]  TIMEOUT_LIMIT = 8'd3;
    localparam logic [16:0] SPEED_MIN     = 17'd1000;
    localparam logic [15:0] SPEED_BONUS   = 16'd10;
    localparam logic [6:0]  BONUS_CAP     = 7'd50;
    localparam int          BONUS_SHIFT   = 6;
    localparam logic [12:0] PEND_WEIGHT   = 13'd6;
    localparam logic [12:0] HAVE_MAX      = 13'h1FFF;

    // rtt / 2000 = (rtt >> 4) / 125, done as a multiply by 2^27 / 125 rounded up.
    // Exact for every 20-bit dividend.
    localparam int          RTT_PRE_SHIFT = 4;
    localparam logic [20:0] RTT_RECIP     = 21'd1073742;
    localparam int          RTT_SHIFT     = 27;
    localparam int          RTT_PROD_W    = 41;
    localparam int          RTT_Q_W       = 14;

    // One peer table entry.
    typedef struct packed {
        logic [16:0] speed;
        logic        choking;
        logic [7:0]  timeouts;
        logic [9:0]  pending;
        logic [23:0] rtt;
        logic [12:0] have;
    } peer_entry_t;

endpackage

`default_nettype wire

// File: rtl/peer_source_selector.sv
// ----------------------------------------------------------------------------
// peer_source_selector: one result transfer per request; select runs a scan that reads one
// peer-table entry per cycle; add runs a column clear of every chunk-store entry through
// the single mask-RAM port pair.
// One request is worked at a time; a new one is taken while the last result waits.
// Reset (aresetn, synchronous, active low) is immediate and runs no memory clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module peer_source_selector #(
    parameter int MAX_CHUNKS = 4096
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    // Configuration write channel.
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [16:0]        cfg_data,

    // Request channel.
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_req_type,
    input  wire logic [3:0]         s_peer_slot,
    input  wire logic [11:0]        s_chunk_index,
    input  wire logic [16:0]        s_link_speed,
    input  wire logic               s_choking,
    input  wire logic [7:0]         s_consecutive_timeouts,
    input  wire logic [9:0]         s_pending,
    input  wire logic [23:0]        s_rtt_us,

    // Result channel.
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_status,
    output logic                    m_found,
    output logic [3:0]              m_best_slot,
    output logic signed [14:0]      m_best_score
);

    // ------------------------------------------------------------------------
    // Sizes derived from the chunk store depth. The clear pointer is one bit
    // wider so that it can run one step past the last entry for the final
    // write-back of the column clear.
    // ------------------------------------------------------------------------
    localparam int              CAW       = $clog2(MAX_CHUNKS);
    localparam int              CNT_W     = CAW + 1;
    localparam logic [CNT_W-1:0] CLR_END  = CNT_W'(MAX_CHUNKS);
    localparam logic [16:0]     CHUNK_LIM = 17'(MAX_CHUNKS);
    localparam int              PEER_W    = $bits(pss_pkg::peer_entry_t);
    localparam int              PEERS     = pss_pkg::PEERS;

    // ------------------------------------------------------------------------
    // Sequencer states.
    // ------------------------------------------------------------------------
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EXEC    = 7'b0000010,
        S_HAVE_WR = 7'b0000100,
        S_UPD_WR  = 7'b0001000,
        S_COLCLR  = 7'b0010000,
        S_SCAN    = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [16:0] local_speed_reg;
    logic [12:0] total_chunks_reg;

    // Captured request.
    logic [2:0]  req_reg;
    logic [3:0]  slot_reg;
    logic [11:0] chunk_reg;
    logic [16:0] speed_in_reg;
    logic        choke_in_reg;
    logic [7:0]  to_in_reg;
    logic [9:0]  pend_in_reg;
    logic [23:0] rtt_in_reg;

    // Peer active bits live in flip-flops so that reset clears them at once.
    logic [PEERS-1:0] active_reg, active_next;

    // Sequencer working registers.
    logic             res_status_reg, res_status_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [3:0]       rd_slot_reg, rd_slot_next;
    logic             rd_more_reg, rd_more_next;
    logic             mask_pend_reg, mask_pend_next;
    logic [PEERS-1:0] mask_word_reg, mask_word_next;

    // Running best of the select scan.
    logic               found_reg, found_next;
    logic [3:0]         best_slot_reg, best_slot_next;
    logic signed [14:0] best_score_reg, best_score_next;
    logic [12:0]        best_have_reg, best_have_next;

    // Output register.
    logic               m_valid_reg, m_valid_next;
    logic               m_status_reg;
    logic               m_found_reg;
    logic [3:0]         m_best_slot_reg;
    logic signed [14:0] m_best_score_reg;
    logic               out_load;

    // Memory ports.
    logic             mask_we;
    logic [CAW-1:0]   mask_waddr, mask_raddr;
    logic [PEERS-1:0] mask_wdata, mask_rdata;
    logic             peer_we;
    logic [3:0]       peer_waddr, peer_raddr;
    pss_pkg::peer_entry_t peer_wdata, peer_rd;
    logic [PEER_W-1:0]    peer_rdata;

    // ------------------------------------------------------------------------
    // Chunk store: one peer-mask word per chunk, bit s for slot s. Its
    // contents are undefined after reset; an add sweeps the slot's column
    // to zero before the add completes, and every use of a bit is gated
    // by the active bit, so stale bits of idle slots are never seen.
    // ------------------------------------------------------------------------
    pss_ram #(
        .WIDTH (PEERS),
        .DEPTH (MAX_CHUNKS)
    ) u_mask_ram (
        .aclk  (aclk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    // Peer table: speed, stats and have count of each slot. An entry is
    // fully written by add before it can be read as an active peer.
    pss_ram #(
        .WIDTH (PEER_W),
        .DEPTH (PEERS)
    ) u_peer_ram (
        .aclk  (aclk),
        .we    (peer_we),
        .waddr (peer_waddr),
        .wdata (peer_wdata),
        .raddr (peer_raddr),
        .rdata (peer_rdata)
    );

    assign peer_rd = pss_pkg::peer_entry_t'(peer_rdata);

    // ------------------------------------------------------------------------
    // Request decode helpers.
    // ------------------------------------------------------------------------
    logic [PEERS-1:0] slot_bit;
    logic [CAW-1:0]   chunk_addr;
    logic [CAW-1:0]   clr_waddr;
    logic             chunk_ok;
    logic             mask_bit_set;

    assign slot_bit   = PEERS'(1) << slot_reg;
    assign chunk_addr = CAW'(chunk_reg);
    assign clr_waddr  = CAW'(ptr_reg - CNT_W'(1));
    assign chunk_ok   = ({1'b0, chunk_reg} < total_chunks_reg) &&
                        ({5'b0, chunk_reg} < CHUNK_LIM);
    assign mask_bit_set = (mask_rdata & slot_bit) != '0;

    // Entry images written by add, update and have.
    pss_pkg::peer_entry_t add_entry, upd_entry, have_entry;

    always_comb begin
        add_entry       = '0;
        add_entry.speed = speed_in_reg;

        upd_entry          = peer_rd;
        upd_entry.speed    = speed_in_reg;
        upd_entry.choking  = choke_in_reg;
        upd_entry.timeouts = to_in_reg;
        upd_entry.pending  = pend_in_reg;
        upd_entry.rtt      = rtt_in_reg;

        have_entry = peer_rd;
        if (peer_rd.have != pss_pkg::HAVE_MAX) begin
            have_entry.have = peer_rd.have + 13'd1;
        end
    end

    // ------------------------------------------------------------------------
    // Score pipeline of the select scan.
    // Stage A: peer entry from RAM; eligibility and score terms, with the
    //          rtt reciprocal multiply registered.
    // Stage B: terms summed into a 15-bit score.
    // Stage C: comparison against the running best.
    // ------------------------------------------------------------------------
    logic        a_vld_reg, a_vld_next;
    logic [3:0]  a_slot_reg;
    logic        a_elig;
    logic        a_spd;
    logic [12:0] a_missing;
    logic [6:0]  a_bonus_raw;
    logic [5:0]  a_bonus;
    logic [12:0] a_pend6;
    logic [pss_pkg::RTT_PROD_W-1:0] a_prod;

    assign a_elig = active_reg[a_slot_reg] && mask_word_reg[a_slot_reg] &&
                    !peer_rd.choking && (peer_rd.timeouts < pss_pkg::TIMEOUT_LIMIT);
    assign a_spd  = (local_speed_reg >= pss_pkg::SPEED_MIN) &&
                    (peer_rd.speed >= pss_pkg::SPEED_MIN);
    assign a_missing   = (total_chunks_reg > peer_rd.have) ?
                         (total_chunks_reg - peer_rd.have) : 13'd0;
    assign a_bonus_raw = 7'(a_missing >> pss_pkg::BONUS_SHIFT);
    assign a_bonus     = (a_bonus_raw > pss_pkg::BONUS_CAP) ?
                         6'(pss_pkg::BONUS_CAP) : a_bonus_raw[5:0];
    assign a_pend6     = 13'(peer_rd.pending) * pss_pkg::PEND_WEIGHT;
    assign a_prod      = pss_pkg::RTT_PROD_W'(peer_rd.rtt >> pss_pkg::RTT_PRE_SHIFT) *
                         pss_pkg::RTT_PROD_W'(pss_pkg::RTT_RECIP);

    logic        b_vld_reg;
    logic        b_elig_reg;
    logic [3:0]  b_slot_reg;
    logic [12:0] b_have_reg;
    logic        b_spd_reg;
    logic [5:0]  b_bonus_reg;
    logic [12:0] b_pend6_reg;
    logic [pss_pkg::RTT_PROD_W-1:0] b_prod_reg;
    logic [pss_pkg::RTT_Q_W-1:0]    b_rtt_q;
    logic [15:0] b_sum;

    // Sum in 16-bit two's complement; the range fits 15 signed bits.
    assign b_rtt_q = pss_pkg::RTT_Q_W'(b_prod_reg >> pss_pkg::RTT_SHIFT);
    assign b_sum   = (b_spd_reg ? pss_pkg::SPEED_BONUS : 16'd0) + 16'(b_bonus_reg)
                     - 16'(b_pend6_reg) - 16'(b_rtt_q);

    logic               c_vld_reg;
    logic               c_elig_reg;
    logic [3:0]         c_slot_reg;
    logic [12:0]        c_have_reg;
    logic signed [14:0] c_score_reg;
    logic               c_better;

    // Higher score wins, then the lower have count; slots arrive in
    // ascending order, so a full tie keeps the earlier slot.
    assign c_better = c_vld_reg && c_elig_reg &&
                      (!found_reg || (c_score_reg > best_score_reg) ||
                       ((c_score_reg == best_score_reg) && (c_have_reg < best_have_reg)));

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        active_next     = active_reg;
        res_status_next = res_status_reg;
        ptr_next        = ptr_reg;
        rd_slot_next    = rd_slot_reg;
        rd_more_next    = rd_more_reg;
        mask_pend_next  = mask_pend_reg;
        mask_word_next  = mask_word_reg;
        found_next      = found_reg;
        best_slot_next  = best_slot_reg;
        best_score_next = best_score_reg;
        best_have_next  = best_have_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_load        = 1'b0;
        a_vld_next      = 1'b0;

        mask_we    = 1'b0;
        mask_waddr = chunk_addr;
        mask_wdata = mask_rdata | slot_bit;
        mask_raddr = chunk_addr;
        peer_we    = 1'b0;
        peer_waddr = slot_reg;
        peer_wdata = upd_entry;
        peer_raddr = slot_reg;

        if (c_better) begin
            found_next      = 1'b1;
            best_slot_next  = c_slot_reg;
            best_score_next = c_score_reg;
            best_have_next  = c_have_reg;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                // Mask and peer reads for have and update are issued here
                // at the default addresses; their data arrives next cycle.
                found_next      = 1'b0;
                best_slot_next  = '0;
                best_score_next = '0;
                res_status_next = pss_pkg::STAT_REJECT;
                state_next      = S_DONE;
                if (req_reg == pss_pkg::REQ_SELECT) begin
                    if (chunk_ok) begin
                        res_status_next = pss_pkg::STAT_DONE;
                        mask_pend_next  = 1'b1;
                        rd_slot_next    = '0;
                        rd_more_next    = 1'b1;
                        state_next      = S_SCAN;
                    end
                end else if (req_reg == pss_pkg::REQ_ADD) begin
                    peer_we               = 1'b1;
                    peer_wdata            = add_entry;
                    active_next[slot_reg] = 1'b1;
                    ptr_next              = '0;
                    res_status_next       = pss_pkg::STAT_DONE;
                    state_next            = S_COLCLR;
                end else if (active_reg[slot_reg]) begin
                    if (req_reg == pss_pkg::REQ_REMOVE) begin
                        active_next[slot_reg] = 1'b0;
                        res_status_next       = pss_pkg::STAT_DONE;
                    end else if (req_reg == pss_pkg::REQ_HAVE) begin
                        if (chunk_ok) begin
                            res_status_next = pss_pkg::STAT_DONE;
                            state_next      = S_HAVE_WR;
                        end
                    end else if (req_reg == pss_pkg::REQ_UPDATE) begin
                        res_status_next = pss_pkg::STAT_DONE;
                        state_next      = S_UPD_WR;
                    end
                end
            end

            S_HAVE_WR: begin
                // A bit already set changes nothing.
                if (!mask_bit_set) begin
                    mask_we    = 1'b1;
                    peer_we    = 1'b1;
                    peer_wdata = have_entry;
                end
                state_next = S_DONE;
            end

            S_UPD_WR: begin
                peer_we    = 1'b1;
                state_next = S_DONE;
            end

            S_COLCLR: begin
                // Read entry ptr while writing back entry ptr - 1 with the
                // slot's bit cleared.
                mask_raddr = ptr_reg[CAW-1:0];
                mask_waddr = clr_waddr;
                mask_wdata = mask_rdata & ~slot_bit;
                mask_we    = (ptr_reg != '0);
                if (ptr_reg == CLR_END) begin
                    state_next = S_DONE;
                end else begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end

            S_SCAN: begin
                if (mask_pend_reg) begin
                    mask_word_next = mask_rdata;
                    mask_pend_next = 1'b0;
                end
                peer_raddr = rd_slot_reg;
                if (rd_more_reg) begin
                    a_vld_next = 1'b1;
                    if (rd_slot_reg == pss_pkg::LAST_SLOT) begin
                        rd_more_next = 1'b0;
                    end else begin
                        rd_slot_next = rd_slot_reg + 4'd1;
                    end
                end
                if (c_vld_reg && (c_slot_reg == pss_pkg::LAST_SLOT)) begin
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            active_reg       <= '0;
            local_speed_reg  <= '0;
            total_chunks_reg <= '0;
            m_valid_reg      <= 1'b0;
            a_vld_reg        <= 1'b0;
            b_vld_reg        <= 1'b0;
            c_vld_reg        <= 1'b0;
            rd_more_reg      <= 1'b0;
            mask_pend_reg    <= 1'b0;
            found_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            m_valid_reg   <= m_valid_next;
            a_vld_reg     <= a_vld_next;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            rd_more_reg   <= rd_more_next;
            mask_pend_reg <= mask_pend_next;
            found_reg     <= found_next;
            // Writes to an index beyond the two registers are dropped.
            if (cfg_valid) begin
                if (cfg_index == pss_pkg::CFG_LOCAL_SPEED) begin
                    local_speed_reg <= cfg_data;
                end else if (cfg_index == pss_pkg::CFG_TOTAL_CHUNKS) begin
                    total_chunks_reg <= cfg_data[12:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Data registers (no reset needed).
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg      <= s_req_type;
            slot_reg     <= s_peer_slot;
            chunk_reg    <= s_chunk_index;
            speed_in_reg <= s_link_speed;
            choke_in_reg <= s_choking;
            to_in_reg    <= s_consecutive_timeouts;
            pend_in_reg  <= s_pending;
            rtt_in_reg   <= s_rtt_us;
        end

        res_status_reg <= res_status_next;
        ptr_reg        <= ptr_next;
        rd_slot_reg    <= rd_slot_next;
        mask_word_reg  <= mask_word_next;
        best_slot_reg  <= best_slot_next;
        best_score_reg <= best_score_next;
        best_have_reg  <= best_have_next;

        a_slot_reg  <= rd_slot_reg;

        b_elig_reg  <= a_elig;
        b_slot_reg  <= a_slot_reg;
        b_have_reg  <= peer_rd.have;
        b_spd_reg   <= a_spd;
        b_bonus_reg <= a_bonus;
        b_pend6_reg <= a_pend6;
        b_prod_reg  <= a_prod;

        c_elig_reg  <= b_elig_reg;
        c_slot_reg  <= b_slot_reg;
        c_have_reg  <= b_have_reg;
        c_score_reg <= signed'(b_sum[14:0]);

        if (out_load) begin
            m_status_reg     <= res_status_reg;
            m_found_reg      <= found_reg;
            m_best_slot_reg  <= best_slot_reg;
            m_best_score_reg <= best_score_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Ports. The request channel is open whenever the sequencer is idle; a
    // finished result sits in the output register and does not hold it off.
    // ------------------------------------------------------------------------
    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found      = m_found_reg;
    assign m_best_slot  = m_best_slot_reg;
    assign m_best_score = m_best_score_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    `ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_valid && s_ready, state_reg == S_EXEC, "accepted transfer did not start execution")
    `ASSERT_IMPL(a_found_done, aclk, aresetn, m_valid && m_found, (m_status == pss_pkg::STAT_DONE) && (m_best_score <= 15'sd60), "found result with bad status or score")
    `ASSERT_IMPL(a_nofound_zero, aclk, aresetn, m_valid && !m_found, (m_best_slot == '0) && (m_best_score == '0), "result without a peer carries nonzero slot or score")
    `ASSERT_IMPL(a_mask_write, aclk, aresetn, mask_we, (state_reg == S_HAVE_WR) || (state_reg == S_COLCLR), "chunk store written outside have or column clear")
    `ASSERT_IMPL(a_scan_pipe, aclk, aresetn, a_vld_reg || b_vld_reg || c_vld_reg, state_reg == S_SCAN, "score pipeline busy outside the scan")

endmodule

`default_nettype wire

// File: rtl/pss_ram.sv
// ----------------------------------------------------------------------------
// pss_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for peer_source_selector
// Drives add, remove, have, update and select requests and unknown codes
// into the block through valid/ready channels. It predicts every reply from
// its own model of the peer table and the chunk mask store, and compares each
// reply transfer with the oldest prediction. A short directed part runs
// first, then four random phases that change the registers and the idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    // Request codes the block must reject.
    localparam logic [2:0] REQ_UNUSED_LO  = 3'd5;
    localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI  = 3'd7;

    // Register indexes with no register behind them; writes there are ignored.
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    // Scoring rules of the selector.
    localparam int SLOT_COUNT       = 16;
    localparam int CHUNK_DEPTH      = 4096;
    localparam int SPEED_FLOOR      = 1000;
    localparam int FAST_BONUS       = 10;
    localparam int MISSING_CAP      = 50;
    localparam int CHUNKS_PER_POINT = 64;
    localparam int PENDING_WEIGHT   = 6;
    localparam int RTT_DIVISOR      = 2000;
    localparam int TIMEOUT_CUTOFF   = 3;
    localparam int HAVE_CEILING     = 8191;

    // Random have and select traffic mostly targets this many low chunks, so
    // that several peers share chunks and the ranking rules get exercised.
    localparam int HOT_CHUNKS = 48;
    localparam int PHASE_ITEMS = 256;

    typedef struct {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [11:0] chunk;
        logic [16:0] speed;
        logic        choking;
        logic [7:0]  timeouts;
        logic [9:0]  pending;
        logic [23:0] rtt;
    } peer_request_t;

    typedef struct {
        logic               status;
        logic               found;
        logic [3:0]         slot;
        logic signed [14:0] score;
    } peer_reply_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data  = '0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_req_type = '0;
    logic [3:0]  s_peer_slot = '0;
    logic [11:0] s_chunk_index = '0;
    logic [16:0] s_link_speed = '0;
    logic        s_choking = 1'b0;
    logic [7:0]  s_consecutive_timeouts = '0;
    logic [9:0]  s_pending = '0;
    logic [23:0] s_rtt_us = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_status;
    logic               m_found;
    logic [3:0]         m_best_slot;
    logic signed [14:0] m_best_score;

    peer_source_selector dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_req_type             (s_req_type),
        .s_peer_slot            (s_peer_slot),
        .s_chunk_index          (s_chunk_index),
        .s_link_speed           (s_link_speed),
        .s_choking              (s_choking),
        .s_consecutive_timeouts (s_consecutive_timeouts),
        .s_pending              (s_pending),
        .s_rtt_us               (s_rtt_us),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_status               (m_status),
        .m_found                (m_found),
        .m_best_slot            (m_best_slot),
        .m_best_score           (m_best_score)
    );

    // ------------------------------------------------------------------------
    // Mirror of the block's state. The mask store starts at zero here; the
    // block does not clear it at reset, but a column is only ever consulted
    // for an active peer, and adding a peer clears its column first, so stale
    // bits can never reach a reply.
    // ------------------------------------------------------------------------
    logic [15:0] mask_by_chunk [CHUNK_DEPTH];
    logic        slot_live     [SLOT_COUNT];
    logic [16:0] slot_speed    [SLOT_COUNT];
    logic        slot_choke    [SLOT_COUNT];
    logic [7:0]  slot_timeouts [SLOT_COUNT];
    logic [9:0]  slot_pending  [SLOT_COUNT];
    logic [23:0] slot_rtt      [SLOT_COUNT];
    logic [12:0] slot_haves    [SLOT_COUNT];
    logic [16:0] cfg_local_speed = '0;
    logic [12:0] cfg_total = '0;

    // Replies predicted for accepted requests, oldest first.
    peer_reply_t predicted_replies [$];

    // Idling knobs, changed per phase.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    // Bookkeeping for the summary and the verdict.
    int requests_sent [8];
    int replies_checked = 0;
    int selects_with_peer = 0;
    int rejects_seen = 0;
    int mismatches = 0;
    int failures = 0;

    peer_reply_t oldest;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop, set far beyond the slowest legal run (adds, each sweeping the
    // whole mask store, dominate it).
    initial begin
        #30_000_000;
        $display("FAIL peer_source_selector");
        $finish;
    end

    // The receiver stalls at random with the current phase's probability.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Every accepted reply is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (predicted_replies.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected reply: status %0b found %0b slot %0d score %0d",
                             m_status, m_found, m_best_slot, m_best_score);
            end else begin
                oldest = predicted_replies.pop_front();
                replies_checked++;
                if (oldest.found)
                    selects_with_peer++;
                if (oldest.status == pss_pkg::STAT_REJECT)
                    rejects_seen++;
                if (m_status !== oldest.status || m_found !== oldest.found ||
                    m_best_slot !== oldest.slot || m_best_score !== oldest.score) begin
                    failures++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Reply %0d differs: expected status %0b found %0b ",
                                  "slot %0d score %0d, got status %0b found %0b ",
                                  "slot %0d score %0d"},
                                 replies_checked, oldest.status, oldest.found,
                                 oldest.slot, oldest.score, m_status, m_found,
                                 m_best_slot, m_best_score);
                end
            end
        end
    end

    // Score of one peer for the current registers.
    function automatic int peer_score(input int s);
        int sc;
        int missing;
        int bonus;
        sc = 0;
        if (int'(cfg_local_speed) >= SPEED_FLOOR && int'(slot_speed[s]) >= SPEED_FLOOR)
            sc = FAST_BONUS;
        missing = 0;
        if (cfg_total > slot_haves[s])
            missing = int'(cfg_total) - int'(slot_haves[s]);
        bonus = missing / CHUNKS_PER_POINT;
        if (bonus > MISSING_CAP)
            bonus = MISSING_CAP;
        return sc + bonus - PENDING_WEIGHT * int'(slot_pending[s])
               - int'(slot_rtt[s]) / RTT_DIVISOR;
    endfunction

    // Applies one accepted request to the mirror and returns its reply.
    function automatic peer_reply_t predict_reply(input peer_request_t r);
        peer_reply_t rep;
        int s;
        int c;
        int sc;
        int best_sc;
        int best_have;
        rep = '{status: pss_pkg::STAT_REJECT, found: 1'b0, slot: '0, score: '0};
        best_sc = 0;
        best_have = 0;
        case (r.kind)
            pss_pkg::REQ_SELECT: begin
                if (r.chunk < cfg_total) begin
                    rep.status = pss_pkg::STAT_DONE;
                    // Scan in slot order; later slots only win by a strictly
                    // better score or, on a tie, by a strictly lower have count.
                    for (s = 0; s < SLOT_COUNT; s++) begin
                        if (slot_live[s] && mask_by_chunk[r.chunk][s] && !slot_choke[s]
                            && int'(slot_timeouts[s]) < TIMEOUT_CUTOFF) begin
                            sc = peer_score(s);
                            if (!rep.found || sc > best_sc ||
                                (sc == best_sc && int'(slot_haves[s]) < best_have)) begin
                                rep.found = 1'b1;
                                rep.slot = 4'(s);
                                best_sc = sc;
                                best_have = int'(slot_haves[s]);
                            end
                        end
                    end
                    rep.score = best_sc[14:0];
                end
            end
            pss_pkg::REQ_ADD: begin
                // A fresh peer, whether or not the slot was in use.
                for (c = 0; c < CHUNK_DEPTH; c++)
                    mask_by_chunk[c][r.slot] = 1'b0;
                slot_live[r.slot] = 1'b1;
                slot_speed[r.slot] = r.speed;
                slot_choke[r.slot] = 1'b0;
                slot_timeouts[r.slot] = '0;
                slot_pending[r.slot] = '0;
                slot_rtt[r.slot] = '0;
                slot_haves[r.slot] = '0;
                rep.status = pss_pkg::STAT_DONE;
            end
            pss_pkg::REQ_REMOVE: begin
                if (slot_live[r.slot]) begin
                    slot_live[r.slot] = 1'b0;
                    rep.status = pss_pkg::STAT_DONE;
                end
            end
            pss_pkg::REQ_HAVE: begin
                if (slot_live[r.slot] && r.chunk < cfg_total) begin
                    // A bit already set is a no-op that still reports done.
                    if (!mask_by_chunk[r.chunk][r.slot]) begin
                        mask_by_chunk[r.chunk][r.slot] = 1'b1;
                        if (int'(slot_haves[r.slot]) < HAVE_CEILING)
                            slot_haves[r.slot] = slot_haves[r.slot] + 13'd1;
                    end
                    rep.status = pss_pkg::STAT_DONE;
                end
            end
            pss_pkg::REQ_UPDATE: begin
                if (slot_live[r.slot]) begin
                    slot_speed[r.slot] = r.speed;
                    slot_choke[r.slot] = r.choking;
                    slot_timeouts[r.slot] = r.timeouts;
                    slot_pending[r.slot] = r.pending;
                    slot_rtt[r.slot] = r.rtt;
                    rep.status = pss_pkg::STAT_DONE;
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    function automatic peer_request_t build_request(
        input logic [2:0] kind, input logic [3:0] slot, input logic [11:0] chunk,
        input logic [16:0] speed, input logic choking, input logic [7:0] timeouts,
        input logic [9:0] pending, input logic [23:0] rtt);
        peer_request_t r;
        r.kind = kind;
        r.slot = slot;
        r.chunk = chunk;
        r.speed = speed;
        r.choking = choking;
        r.timeouts = timeouts;
        r.pending = pending;
        r.rtt = rtt;
        return r;
    endfunction

    // Sends one request and records its predicted reply once the transfer
    // happens. Valid stays high after the transfer until the next call idles or a
    // drain lowers it, so it is never lowered and raised in the same time step.
    task automatic issue_request(input peer_request_t r);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= r.kind;
        s_peer_slot <= r.slot;
        s_chunk_index <= r.chunk;
        s_link_speed <= r.speed;
        s_choking <= r.choking;
        s_consecutive_timeouts <= r.timeouts;
        s_pending <= r.pending;
        s_rtt_us <= r.rtt;
        do @(posedge aclk); while (!s_ready);
        predicted_replies.insert(predicted_replies.size(), predict_reply(r));
        requests_sent[r.kind]++;
    endtask

    // Holds the sender back until every predicted reply has come out.
    task automatic drain_replies();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (predicted_replies.size() != 0)
            @(posedge aclk);
    endtask

    // One register write; only called while the block has nothing in flight.
    task automatic write_register(input logic [1:0] index, input logic [16:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            pss_pkg::CFG_LOCAL_SPEED:  cfg_local_speed = value;
            pss_pkg::CFG_TOTAL_CHUNKS: cfg_total = value[12:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly hot chunks, some anywhere in the 12-bit range, some right at the
    // edge of the configured chunk count.
    function automatic logic [11:0] pick_chunk();
        int lim;
        int roll;
        lim = (int'(cfg_total) > CHUNK_DEPTH) ? CHUNK_DEPTH : int'(cfg_total);
        if (lim > HOT_CHUNKS)
            lim = HOT_CHUNKS;
        roll = $urandom_range(0, 99);
        if (lim > 0 && roll < 75)
            return 12'($urandom_range(0, lim - 1));
        if (roll < 88)
            return 12'($urandom);
        return 12'(int'(cfg_total) + int'($urandom_range(0, 2)) - 1);
    endfunction

    function automatic logic [16:0] pick_speed();
        case ($urandom_range(0, 4))
            0: return 17'd999;
            1: return 17'd1000;
            2: return 17'd100000;
            3: return 17'($urandom_range(0, 100000));
            default: return 17'($urandom);
        endcase
    endfunction

    // Random request: every field carries random bits, then the fields that
    // matter are shaped so that most traffic hits live peers and hot chunks.
    function automatic peer_request_t random_request();
        peer_request_t r;
        int live [$];
        int roll;
        int s;
        for (s = 0; s < SLOT_COUNT; s++)
            if (slot_live[s])
                live.insert(live.size(), s);
        r = build_request(pss_pkg::REQ_SELECT, 4'($urandom), pick_chunk(), 17'($urandom),
                          1'($urandom), 8'($urandom), 10'($urandom), 24'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 4)
            r.kind = pss_pkg::REQ_ADD;
        else if (roll < 7)
            r.kind = pss_pkg::REQ_REMOVE;
        else if (roll < 47)
            r.kind = pss_pkg::REQ_HAVE;
        else if (roll < 65)
            r.kind = pss_pkg::REQ_UPDATE;
        else if (roll < 97)
            r.kind = pss_pkg::REQ_SELECT;
        else
            r.kind = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        if ((r.kind == pss_pkg::REQ_REMOVE || r.kind == pss_pkg::REQ_HAVE ||
             r.kind == pss_pkg::REQ_UPDATE) &&
            live.size() > 0 && $urandom_range(0, 99) < 90)
            r.slot = 4'(live[$urandom_range(0, live.size() - 1)]);
        if (r.kind == pss_pkg::REQ_ADD || r.kind == pss_pkg::REQ_UPDATE)
            r.speed = pick_speed();
        // Most updates keep the peer plausible so that scores stay close and
        // ties, timeouts near the cutoff and choking all come up often.
        if (r.kind == pss_pkg::REQ_UPDATE && $urandom_range(0, 99) < 65) begin
            r.timeouts = 8'($urandom_range(0, 4));
            r.choking = ($urandom_range(0, 3) == 0);
            r.pending = 10'($urandom_range(0, 3));
            r.rtt = 24'($urandom_range(0, 6000));
        end
        return r;
    endfunction

    // With nothing configured, selects are out of range, the table is empty,
    // and the unused request codes are turned away.
    task automatic test_idle_block_rejects();
        issue_request(build_request(pss_pkg::REQ_SELECT, 4'd0, 12'd0, '0, 1'b0, '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_REMOVE, 4'd3, 12'd0, '0, 1'b0, '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_UPDATE, 4'd3, 12'd0, 17'd1000, 1'b0,
                                    '0, '0, '0));
        issue_request(build_request(REQ_UNUSED_LO, 4'd0, 12'd0, '0, 1'b0, '0, '0, '0));
        issue_request(build_request(REQ_UNUSED_MID, 4'd0, 12'd0, '0, 1'b0, '0, '0, '0));
        issue_request(build_request(REQ_UNUSED_HI, 4'hF, 12'hFFF, '1, 1'b1, '1, '1, '1));
        drain_replies();
    endtask

    // Writes to the spare indexes must be ignored; the extremes of both
    // registers are written before settling on the values the next test uses.
    task automatic test_register_writes();
        write_register(CFG_SPARE_A, 17'h1FFFF);
        write_register(CFG_SPARE_B, 17'h1FFFF);
        write_register(pss_pkg::CFG_LOCAL_SPEED, 17'h1FFFF);
        write_register(pss_pkg::CFG_TOTAL_CHUNKS, 17'h1FFFF);
        write_register(pss_pkg::CFG_LOCAL_SPEED, 17'd1000);
        write_register(pss_pkg::CFG_TOTAL_CHUNKS, 17'd4096);
    endtask

    // Two peers on the last chunk: slot order, have count, choking, the
    // timeout cutoff and the most negative score decide in turn.
    task automatic test_select_ranking();
        issue_request(build_request(pss_pkg::REQ_ADD, 4'd0, 12'd0, 17'd1000, 1'b0,
                                    '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_ADD, 4'd15, 12'd0, 17'h1FFFF, 1'b0,
                                    '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_HAVE, 4'd0, 12'hFFF, '0, 1'b0, '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_HAVE, 4'd15, 12'hFFF, '0, 1'b0, '0, '0, '0));
        // Repeated have on a chunk the peer already holds.
        issue_request(build_request(pss_pkg::REQ_HAVE, 4'd15, 12'hFFF, '0, 1'b0, '0, '0, '0));
        // Equal score and have count: the lower slot wins.
        issue_request(build_request(pss_pkg::REQ_SELECT, 4'd0, 12'hFFF, '0, 1'b0,
                                    '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_HAVE, 4'd15, 12'd0, '0, 1'b0, '0, '0, '0));
        // Equal score again, but slot 0 now holds fewer chunks.
        issue_request(build_request(pss_pkg::REQ_SELECT, 4'd0, 12'hFFF, '0, 1'b0,
                                    '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_UPDATE, 4'd0, 12'd0, 17'd1000, 1'b1,
                                    '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_SELECT, 4'd0, 12'hFFF, '0, 1'b0,
                                    '0, '0, '0));
        // Exactly at the timeout cutoff, slot 0 stays out of the running.
        issue_request(build_request(pss_pkg::REQ_UPDATE, 4'd0, 12'd0, 17'd1000, 1'b0,
                                    8'd3, '0, '0));
        issue_request(build_request(pss_pkg::REQ_UPDATE, 4'd15, 12'd0, 17'd0, 1'b0, 8'd2,
                                    10'h3FF, 24'hFFFFFF));
        issue_request(build_request(pss_pkg::REQ_SELECT, 4'd0, 12'hFFF, '0, 1'b0,
                                    '0, '0, '0));
        drain_replies();
    endtask

    // Re-adding a live peer wipes its chunks; remove works once only, and
    // a removed peer can no longer report chunks.
    task automatic test_peer_lifecycle();
        issue_request(build_request(pss_pkg::REQ_ADD, 4'd15, 12'd0, 17'd0, 1'b0, '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_SELECT, 4'd0, 12'hFFF, '0, 1'b0,
                                    '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_REMOVE, 4'd0, 12'd0, '0, 1'b0, '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_REMOVE, 4'd0, 12'd0, '0, 1'b0, '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_HAVE, 4'd0, 12'd1, '0, 1'b0, '0, '0, '0));
        drain_replies();
    endtask

    // Chunks at and just below the configured count.
    task automatic test_chunk_range();
        write_register(pss_pkg::CFG_TOTAL_CHUNKS, 17'd100);
        issue_request(build_request(pss_pkg::REQ_SELECT, 4'd0, 12'd100, '0, 1'b0,
                                    '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_HAVE, 4'd15, 12'd100, '0, 1'b0, '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_HAVE, 4'd15, 12'd99, '0, 1'b0, '0, '0, '0));
        issue_request(build_request(pss_pkg::REQ_SELECT, 4'd0, 12'd99, '0, 1'b0,
                                    '0, '0, '0));
        drain_replies();
    endtask

    // Four phases, each with its own register setting and idling pattern.
    // The table is seeded with a few peers first so that selects find
    // candidates from the start; after that adds and removes are rare, since
    // an add costs a full sweep of the mask store.
    task automatic test_random_traffic();
        int phase;
        int n;
        int s;
        for (phase = 0; phase < 4; phase++) begin
            drain_replies();
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                    write_register(pss_pkg::CFG_LOCAL_SPEED, 17'd1000);
                    write_register(pss_pkg::CFG_TOTAL_CHUNKS, 17'd4096);
                end
                1: begin
                    sender_idle_pct = 84;
                    receiver_stall_pct = 0;
                    write_register(pss_pkg::CFG_LOCAL_SPEED, 17'd999);
                    write_register(pss_pkg::CFG_TOTAL_CHUNKS, 17'd64);
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 84;
                    write_register(pss_pkg::CFG_LOCAL_SPEED, 17'd100000);
                    write_register(pss_pkg::CFG_TOTAL_CHUNKS, 17'd3300);
                end
                default: begin
                    sender_idle_pct = 31;
                    receiver_stall_pct = 31;
                    write_register(pss_pkg::CFG_LOCAL_SPEED, 17'd0);
                    write_register(pss_pkg::CFG_TOTAL_CHUNKS, 17'h1FFFF);
                end
            endcase
            if (phase == 0)
                for (s = 0; s < 8; s++)
                    issue_request(build_request(pss_pkg::REQ_ADD, 4'(s), pick_chunk(),
                                                pick_speed(), 1'($urandom), 8'($urandom),
                                                10'($urandom), 24'($urandom)));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                issue_request(random_request());
                // Now and then the sender waits for the block to empty out.
                if ($urandom_range(0, 99) == 0)
                    drain_replies();
            end
        end
        drain_replies();
    endtask

    initial begin
        int c;
        for (c = 0; c < CHUNK_DEPTH; c++)
            mask_by_chunk[c] = '0;
        for (c = 0; c < SLOT_COUNT; c++) begin
            slot_live[c] = 1'b0;
            slot_speed[c] = '0;
            slot_choke[c] = 1'b0;
            slot_timeouts[c] = '0;
            slot_pending[c] = '0;
            slot_rtt[c] = '0;
            slot_haves[c] = '0;
        end
        for (c = 0; c < 8; c++)
            requests_sent[c] = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_block_rejects();
        test_register_writes();
        test_select_ranking();
        test_peer_lifecycle();
        test_chunk_range();
        test_random_traffic();

        // Give the block time to show any reply it should not produce.
        sender_idle_pct = 0;
        repeat (40) @(posedge aclk);
        if (predicted_replies.size() != 0) begin
            failures++;
            $display("%0d predicted replies never came out", predicted_replies.size());
        end

        $display("Sent %0d add, %0d remove, %0d have, %0d update, %0d select, %0d unknown.",
                 requests_sent[pss_pkg::REQ_ADD], requests_sent[pss_pkg::REQ_REMOVE],
                 requests_sent[pss_pkg::REQ_HAVE], requests_sent[pss_pkg::REQ_UPDATE],
                 requests_sent[pss_pkg::REQ_SELECT],
                 requests_sent[REQ_UNUSED_LO] + requests_sent[REQ_UNUSED_MID]
                 + requests_sent[REQ_UNUSED_HI]);
        $display("Checked %0d replies: %0d selects named a peer, %0d rejects, %0d failures.",
                 replies_checked, selects_with_peer, rejects_seen, failures);
        if (failures == 0)
            $display("PASS peer_source_selector");
        else
            $display("FAIL peer_source_selector");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/pss_pkg.sv
rtl/pss_ram.sv
rtl/peer_source_selector.sv
bench/tb.sv
